[rtl/tkh_pkg.sv]
// ----------------------------------------------------------------------------
// tkh_pkg: shared definitions for the top-k heap selector
// Field widths, register indexes, fill values, the datapath operation codes,
// the status bundle returned by the datapath and the heap order compare.
// ----------------------------------------------------------------------------
package tkh_pkg;

	localparam int MAX_KEEP_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int KEEP_W       = 7;
	localparam int INDEX_OUT_W  = 6;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_SMALLEST = 1'd1;

	localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST = 7'd8;
	localparam logic [VALUE_W-1:0] FILL_SMALLEST  = 32'hFFFF_FFFF;
	localparam logic [VALUE_W-1:0] FILL_LARGEST   = 32'h0000_0000;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_CHECK,
		OP_SIFT,
		OP_EMIT_RD,
		OP_EMIT_LD
	} dp_op_t;

	typedef struct packed {
		logic beats;      // captured value beats the current root
		logic descend;    // sift step moves the hole down one level
		logic last;       // captured request closes the set
		logic out_free;   // output register can take a result this cycle
		logic emit_last;  // entry being emitted is the final one
	} dp_status_t;

	// True when a belongs above b in the heap of the selected mode.
	function automatic logic above(input logic [VALUE_W-1:0] a,
	                               input logic [VALUE_W-1:0] b,
	                               input logic smallest);
		return smallest ? (a > b) : (a < b);
	endfunction

endpackage

[rtl/topk_heap_select.sv]
// ----------------------------------------------------------------------------
// topk_heap_select: streaming top-k selection in a binary heap
// Keeps the k largest or k smallest values of a set and emits them in heap
// array order when the set's last value arrives.
// ----------------------------------------------------------------------------
// A value that does not beat the root passes through the accept step and the
// root check. A value that beats it then sinks in sift steps, one for each
// heap level that it moves down and a last one that writes it in place. The
// sift-down loop reads both children from the two read ports of the heap RAM
// and writes one entry each cycle. After the last request of a set the k
// entries leave one by one, each read from the heap RAM and then loaded into
// the output register once that register is free. A refill needs no pass
// over the RAM: every entry has a valid bit and an entry not written since
// the refill reads as the fill value. A register write starts a new set.
module topk_heap_select #(
	parameter int MAX_KEEP = tkh_pkg::MAX_KEEP_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tkh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tkh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tkh_pkg::VALUE_W-1:0]     sample_value,
	input  logic                            last_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tkh_pkg::VALUE_W-1:0]     kept_value,
	output logic [tkh_pkg::INDEX_OUT_W-1:0] kept_index,
	output logic                            last_result
);

	tkh_pkg::dp_op_t     op;
	tkh_pkg::dp_status_t status;

	tkh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	tkh_datapath #(
		.MAX_KEEP (MAX_KEEP)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.status       (status),
		.sample_value (sample_value),
		.last_sample  (last_sample),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.kept_value   (kept_value),
		.kept_index   (kept_index),
		.last_result  (last_result)
	);

endmodule

[rtl/tkh_ram.sv]
// ----------------------------------------------------------------------------
// tkh_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tkh_ram #(
	parameter int WIDTH = tkh_pkg::VALUE_W,
	parameter int DEPTH = tkh_pkg::MAX_KEEP_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/tkh_datapath.sv]
// ----------------------------------------------------------------------------
// tkh_datapath: heap store, compare logic and output register
// Holds the configuration, the heap RAM with per-entry valid bits, the
// sift-down compare and the result register, all driven by operation codes.
// ----------------------------------------------------------------------------
module tkh_datapath #(
	parameter int MAX_KEEP = tkh_pkg::MAX_KEEP_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tkh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tkh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  tkh_pkg::dp_op_t                     op,
	output tkh_pkg::dp_status_t                 status,
	input  logic [tkh_pkg::VALUE_W-1:0]         sample_value,
	input  logic                                last_sample,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tkh_pkg::VALUE_W-1:0]         kept_value,
	output logic [tkh_pkg::INDEX_OUT_W-1:0]     kept_index,
	output logic                                last_result
);

	localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KW = $clog2(MAX_KEEP + 1);
	localparam int CW = KW + 1;
	localparam logic [KW-1:0] K_MAX = KW'(MAX_KEEP);

	logic [tkh_pkg::KEEP_W-1:0]      keep_count_q;
	logic                            smallest_q;
	logic [MAX_KEEP-1:0]             valid_q;
	logic [tkh_pkg::VALUE_W-1:0]     value_q;
	logic                            last_q;
	logic [AW-1:0]                   pos_q;
	logic [AW-1:0]                   idx_q;
	logic                            va_a_q;
	logic                            va_b_q;
	logic                            out_valid_q;
	logic [tkh_pkg::VALUE_W-1:0]     out_value_q;
	logic [tkh_pkg::INDEX_OUT_W-1:0] out_index_q;
	logic                            out_last_q;

	logic [KW-1:0]               k;
	logic [tkh_pkg::VALUE_W-1:0] fill;
	logic [tkh_pkg::VALUE_W-1:0] rd_a;
	logic [tkh_pkg::VALUE_W-1:0] rd_b;
	logic [tkh_pkg::VALUE_W-1:0] val_a;
	logic [tkh_pkg::VALUE_W-1:0] val_b;
	logic [tkh_pkg::VALUE_W-1:0] cand;
	logic [tkh_pkg::VALUE_W-1:0] child_val;
	logic [CW-1:0]               l_idx;
	logic [CW-1:0]               r_idx;
	logic [CW-1:0]               best;
	logic [CW-1:0]               next_l;
	logic [CW-1:0]               next_r;
	logic [CW-1:0]               root_l;
	logic [CW-1:0]               root_r;
	logic                        l_ok;
	logic                        r_ok;
	logic                        take_l;
	logic                        take_r;
	logic                        descend;
	logic                        out_free;
	logic                        emit_last;
	logic                        ram_we;
	logic [AW-1:0]               ram_wa;
	logic [tkh_pkg::VALUE_W-1:0] ram_wd;
	logic [AW-1:0]               ra_a;
	logic [AW-1:0]               ra_b;

	tkh_ram #(
		.WIDTH (tkh_pkg::VALUE_W),
		.DEPTH (MAX_KEEP)
	) u_heap_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_wa),
		.wdata   (ram_wd),
		.raddr_a (ra_a),
		.raddr_b (ra_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		if (keep_count_q == '0) begin
			k = KW'(1);
		end else if (keep_count_q > tkh_pkg::KEEP_W'(MAX_KEEP)) begin
			k = K_MAX;
		end else begin
			k = keep_count_q[KW-1:0];
		end
	end

	// An entry never written since the last refill reads as the fill value.
	assign fill  = smallest_q ? tkh_pkg::FILL_SMALLEST : tkh_pkg::FILL_LARGEST;
	assign val_a = va_a_q ? rd_a : fill;
	assign val_b = va_b_q ? rd_b : fill;

	assign l_idx = CW'({pos_q, 1'b0}) + CW'(1);
	assign r_idx = l_idx + CW'(1);
	assign l_ok  = l_idx < CW'(k);
	assign r_ok  = r_idx < CW'(k);

	// The value being sifted rides in value_q; the left child wins ties.
	assign take_l    = l_ok && tkh_pkg::above(val_a, value_q, smallest_q);
	assign cand      = take_l ? val_a : value_q;
	assign take_r    = r_ok && tkh_pkg::above(val_b, cand, smallest_q);
	assign descend   = take_l || take_r;
	assign best      = take_r ? r_idx : l_idx;
	assign child_val = take_r ? val_b : val_a;
	assign next_l    = {best[CW-2:0], 1'b0} + CW'(1);
	assign next_r    = next_l + CW'(1);
	assign root_l    = CW'(1);
	assign root_r    = CW'(2);

	assign out_free  = !out_valid_q || out_ready;
	assign emit_last = (KW'(idx_q) == (k - KW'(1)));

	always_comb begin
		ram_we = 1'b0;
		ram_wa = pos_q;
		ram_wd = value_q;
		ra_a   = '0;
		ra_b   = '0;
		unique case (op)
			tkh_pkg::OP_NONE: begin
			end
			tkh_pkg::OP_CAPTURE: begin
				ra_a = '0;
			end
			tkh_pkg::OP_CHECK: begin
				ra_a = root_l[AW-1:0];
				ra_b = root_r[AW-1:0];
			end
			tkh_pkg::OP_SIFT: begin
				ram_we = 1'b1;
				ram_wd = descend ? child_val : value_q;
				ra_a   = next_l[AW-1:0];
				ra_b   = next_r[AW-1:0];
			end
			tkh_pkg::OP_EMIT_RD, tkh_pkg::OP_EMIT_LD: begin
				ra_a = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tkh_pkg::KEEP_COUNT_RST;
			smallest_q   <= 1'b0;
			valid_q      <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (op != tkh_pkg::OP_EMIT_LD)) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				tkh_pkg::OP_CAPTURE: begin
					idx_q <= '0;
				end
				tkh_pkg::OP_CHECK: begin
					pos_q <= '0;
				end
				tkh_pkg::OP_SIFT: begin
					valid_q[pos_q] <= 1'b1;
					if (descend) begin
						pos_q <= best[AW-1:0];
					end
				end
				tkh_pkg::OP_EMIT_LD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + AW'(1);
						// The set is done: start the next one from the fill value.
						if (emit_last) begin
							valid_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					tkh_pkg::REG_KEEP_COUNT:      keep_count_q <= cfg_data;
					tkh_pkg::REG_SELECT_SMALLEST: smallest_q   <= cfg_data[0];
					default: begin
					end
				endcase
				valid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		va_a_q <= valid_q[ra_a];
		va_b_q <= valid_q[ra_b];
		if (op == tkh_pkg::OP_CAPTURE) begin
			value_q <= sample_value;
			last_q  <= last_sample;
		end
		if ((op == tkh_pkg::OP_EMIT_LD) && out_free) begin
			out_value_q <= val_a;
			out_index_q <= tkh_pkg::INDEX_OUT_W'(idx_q);
			out_last_q  <= emit_last;
		end
	end

	assign status.beats     = tkh_pkg::above(val_a, value_q, smallest_q);
	assign status.descend   = descend;
	assign status.last      = last_q;
	assign status.out_free  = out_free;
	assign status.emit_last = emit_last;

	assign out_valid   = out_valid_q;
	assign kept_value  = out_value_q;
	assign kept_index  = out_index_q;
	assign last_result = out_last_q;

endmodule

[rtl/tkh_ctrl.sv]
// ----------------------------------------------------------------------------
// tkh_ctrl: sequencer for the top-k heap selector
// Steps each request through the root check, a sift-down when it beats the
// root and, at the end of a set, the emission of the kept entries.
// ----------------------------------------------------------------------------
module tkh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tkh_pkg::dp_status_t status,
	output tkh_pkg::dp_op_t     op
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SIFT,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;

	always_comb begin
		state_d = state_q;
		op      = tkh_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = tkh_pkg::OP_CAPTURE;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				op = tkh_pkg::OP_CHECK;
				if (status.beats) begin
					state_d = S_SIFT;
				end else if (status.last) begin
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SIFT: begin
				op = tkh_pkg::OP_SIFT;
				if (!status.descend) begin
					state_d = status.last ? S_EMIT_RD : S_IDLE;
				end
			end
			S_EMIT_RD: begin
				op      = tkh_pkg::OP_EMIT_RD;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				op = tkh_pkg::OP_EMIT_LD;
				if (status.out_free) begin
					state_d = status.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = in_ready_q;

endmodule

[rtl/tkh_checker.sv]
// ----------------------------------------------------------------------------
// tkh_checker: port-level assertions for the top-k heap selector
// Watches the handshakes and the order of emitted entries; bound to the top.
// ----------------------------------------------------------------------------
module tkh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tkh_pkg::VALUE_W-1:0]     kept_value,
	input logic [tkh_pkg::INDEX_OUT_W-1:0] kept_index,
	input logic                            last_result
);

	logic [tkh_pkg::INDEX_OUT_W-1:0] exp_idx_q;

	// Position expected for the next emitted entry of the current set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= last_result ? '0 : exp_idx_q + tkh_pkg::INDEX_OUT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kept_value) &&
			$stable(kept_index) && $stable(last_result))
		else $error("stalled result changed or dropped");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kept_index == exp_idx_q)
		else $error("entries not emitted in heap array order");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while the previous one is in progress");

endmodule

bind topk_heap_select tkh_checker u_tkh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kept_value  (kept_value),
	.kept_index  (kept_index),
	.last_result (last_result)
);

[tb/tb_topk_heap_select.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topk_heap_select: self-checking bench for the top-k heap selector
// Streams sets of 32-bit values with random pacing on both channels. A mirror
// heap in the bench predicts the kept values emitted at the end of each set.
// The run starts with a directed table and then moves through random phases,
// with keep counts from 0 to 127 and both selection modes.
// ----------------------------------------------------------------------------
module tb_topk_heap_select;
	import tkh_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int ITEMS_TOTAL    = 280;
	localparam int SETTLE_CYCLES  = 24;
	localparam int END_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_ROWS  = 33;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum bit [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_STARVE} stall_pattern_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]  reg_data;
		logic [VALUE_W-1:0]     value;
		logic                   closes;
		logic                   root_typed;
		logic [VALUE_W-1:0]     root_value;
	} step_row_t;

	typedef struct {
		logic [VALUE_W-1:0]     value;
		logic [INDEX_OUT_W-1:0] position;
		logic                   closes;
	} kept_entry_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_KEEP_COUNT;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [VALUE_W-1:0]     sample_value = '0;
	logic                   last_sample = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VALUE_W-1:0]     kept_value;
	logic [INDEX_OUT_W-1:0] kept_index;
	logic                   last_result;

	// Mirror of the block: heap contents and the two registers.
	logic [VALUE_W-1:0]     heap_mirror [MAX_KEEP_DEF];
	logic [KEEP_W-1:0]      mirror_keep;
	logic                   mirror_smallest;
	kept_entry_t            kept_due [$];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned sets_closed = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned partial_sets = 0;
	int unsigned burst_left = 0;
	bit          valid_up = 1'b0;

	stall_pattern_t stall_mode = RX_OPEN;
	int unsigned    stall_left = 0;

	// Root rows carry a typed root value; all other fields come from the mirror.
	step_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd1, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd0, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0002, 1'b1, 1'b1, 32'h0000_0003},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd127, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0009, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_WRITE,  REG_SELECT_SMALLEST, 7'h01, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd3, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005},
		'{ROW_WRITE,  REG_SELECT_SMALLEST, 7'h7E, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd64, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd65, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd2, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFE},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_WRITE,  REG_KEEP_COUNT, 7'd2, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h0000_0003, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_WRITE,  REG_SELECT_SMALLEST, 7'h01, 32'h0, 1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_KEEP_COUNT, 7'd0, 32'h5555_5555, 1'b1, 1'b1, 32'hFFFF_FFFF}
	};

	topk_heap_select dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kept_value   (kept_value),
		.kept_index   (kept_index),
		.last_result  (last_result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void mirror_refill();
		for (int i = 0; i < MAX_KEEP_DEF; i++) begin
			heap_mirror[i] = mirror_smallest ? FILL_SMALLEST : FILL_LARGEST;
		end
	endfunction

	// True when a sits nearer the root than b in the current mode.
	function automatic bit ranks_higher(input logic [VALUE_W-1:0] a,
	                                    input logic [VALUE_W-1:0] b);
		return mirror_smallest ? (a > b) : (a < b);
	endfunction

	function automatic void mirror_config(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_KEEP_COUNT) begin
			mirror_keep = data[KEEP_W-1:0];
		end else if (idx == REG_SELECT_SMALLEST) begin
			mirror_smallest = data[0];
		end
		mirror_refill();
	endfunction

	// Folds one value into the mirror heap and queues the kept values when the
	// value closes its set.
	function automatic void predict_kept(input logic [VALUE_W-1:0] value,
	                                     input logic closes,
	                                     input logic root_typed,
	                                     input logic [VALUE_W-1:0] root_value);
		int unsigned       k;
		int unsigned       pos;
		int unsigned       lc;
		int unsigned       rc;
		int unsigned       best;
		bit                done;
		logic [VALUE_W-1:0] swap;
		kept_entry_t       entry;
		k = (mirror_keep == 0) ? 1 : ((mirror_keep > MAX_KEEP_DEF) ? MAX_KEEP_DEF : mirror_keep);
		if (ranks_higher(heap_mirror[0], value)) begin
			heap_mirror[0] = value;
			pos = 0;
			done = 1'b0;
			while (!done) begin
				lc = 2 * pos + 1;
				rc = 2 * pos + 2;
				best = pos;
				// On equal children the left one wins, as the right must strictly beat it.
				if (lc < k && ranks_higher(heap_mirror[lc], heap_mirror[best])) best = lc;
				if (rc < k && ranks_higher(heap_mirror[rc], heap_mirror[best])) best = rc;
				if (best == pos) begin
					done = 1'b1;
				end else begin
					swap = heap_mirror[pos];
					heap_mirror[pos] = heap_mirror[best];
					heap_mirror[best] = swap;
					pos = best;
				end
			end
		end
		if (closes) begin
			for (int i = 0; i < k; i++) begin
				entry.value = (i == 0 && root_typed) ? root_value : heap_mirror[i];
				entry.position = INDEX_OUT_W'(i);
				entry.closes = (i + 1 == k);
				kept_due.push_back(entry);
			end
			mirror_refill();
			sets_closed++;
		end
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return FILL_LARGEST;
			1: return FILL_SMALLEST;
			2, 3: return VALUE_W'($urandom_range(0, 15));
			4: return VALUE_W'($urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF));
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	task automatic lower_valid();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	task automatic send_sample(input logic [VALUE_W-1:0] value, input logic closes,
	                           input logic root_typed, input logic [VALUE_W-1:0] root_value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				lower_valid();
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		valid_up = 1'b1;
		sample_value <= value;
		last_sample <= closes;
		do @(posedge clk); while (!in_ready);
		predict_kept(value, closes, root_typed, root_value);
		items_sent++;
	endtask

	task automatic drain_results();
		lower_valid();
		while (kept_due.size() != 0) @(posedge clk);
	endtask

	// Registers change only while the block is idle, after any sift has settled.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_config(idx, data);
		reg_writes++;
	endtask

	always @(posedge clk) begin : result_check
		kept_entry_t due;
		if (arst_n && out_valid && out_ready) begin
			if (kept_due.size() == 0) begin
				report($sformatf("result with nothing pending: value %h index %0d",
				                 kept_value, kept_index));
			end else begin
				due = kept_due.pop_front();
				if (kept_value !== due.value)
					report($sformatf("kept_value at index %0d: expected %h, got %h",
					                 due.position, due.value, kept_value));
				if (kept_index !== due.position)
					report($sformatf("kept_index: expected %0d, got %0d",
					                 due.position, kept_index));
				if (last_result !== due.closes)
					report($sformatf("last_result at index %0d: expected %b, got %b",
					                 due.position, due.closes, last_result));
				results_checked++;
			end
		end
		if (stall_left == 0) begin
			stall_mode = stall_pattern_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned plan;
		int unsigned pick;
		int unsigned keep_pick;
		int unsigned n_sets;
		int unsigned len;
		mirror_keep = KEEP_COUNT_RST;
		mirror_smallest = 1'b0;
		mirror_refill();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_WRITE)
				write_reg(directed_rows[r].reg_index, directed_rows[r].reg_data);
			else
				send_sample(directed_rows[r].value, directed_rows[r].closes,
				            directed_rows[r].root_typed, directed_rows[r].root_value);
		end

		// Each phase picks new registers and then streams whole sets, sometimes
		// ending on a set that the next register write cuts short.
		while (items_sent < ITEMS_TOTAL) begin
			plan = $urandom_range(0, 3);
			if (plan != 1) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)      keep_pick = 0;
				else if (pick == 1) keep_pick = MAX_KEEP_DEF;
				else if (pick == 2) keep_pick = $urandom_range(MAX_KEEP_DEF + 1, 127);
				else if (pick == 3) keep_pick = $urandom_range(10, 40);
				else                keep_pick = $urandom_range(1, 9);
				write_reg(REG_KEEP_COUNT, CFG_DATA_W'(keep_pick));
			end
			if (plan != 0)
				write_reg(REG_SELECT_SMALLEST, CFG_DATA_W'($urandom_range(0, 127)));
			n_sets = $urandom_range(2, 6);
			for (int s = 0; s < n_sets; s++) begin
				len = $urandom_range(1, 14);
				for (int j = 0; j < len; j++)
					send_sample(pick_value(), j == len - 1, 1'b0, '0);
				if ($urandom_range(0, 4) == 0)
					drain_results();
			end
			if ($urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 4);
				for (int j = 0; j < len; j++)
					send_sample(pick_value(), 1'b0, 1'b0, '0);
				partial_sets++;
			end
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		$display("Run covered %0d samples in %0d closed sets and %0d cut short by a write.",
		         items_sent, sets_closed, partial_sets);
		$display("Checked %0d kept values after %0d register writes; %0d mismatches.",
		         results_checked, reg_writes, error_count);
		if (error_count == 0 && kept_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
